// File: src/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg: shared types for the LIFO stack with search
// Action and status codes, datapath operation codes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lss_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_SEARCH = 3'd4,
        ACT_COUNT  = 3'd5,
        ACT_CLEAR  = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_BEYOND   = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,      // hold
        OP_LATCH,     // capture the item, reset the result staging
        OP_FAIL,      // stage an error status
        OP_PUSH,      // write top, count up
        OP_CLEAR,     // count to zero
        OP_RD_TOP,    // read the top entry, start a walk from the top
        OP_RD_SLOT,   // read the entry at the removal slot
        OP_TAKE,      // stage read data, count down on pop
        OP_REM_TAKE,  // stage removed data, read the entry above
        OP_SHIFT,     // move one entry down, read the next one
        OP_SCAN,      // compare one entry, step down
        OP_LOAD       // move the staged result to the output register
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status st;
    } t_cmd;

    typedef struct packed {
        logic [2:0] act;         // latched action code
        logic       full;
        logic       empty;
        logic       pos_zero;
        logic       pos_beyond;
        logic       more;        // an entry sits above the current pointer
        logic       shift_more;  // another move follows this one
        logic       match;
        logic       scan_more;
        logic       out_free;
    } t_sts;

endpackage

// File: src/lss_if.sv
// ----------------------------------------------------------------------------
// lss_if: item channels of the LIFO stack with search
// Valid/ready channels for the requests and for the results.
// ----------------------------------------------------------------------------
interface lss_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] age;
    logic [3:0] position;

    modport source (output valid, action, age, position, input ready);
    modport sink   (input valid, action, age, position, output ready);
endinterface

interface lss_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] data_age;
    logic [4:0] found_position;
    logic [4:0] entry_count;

    modport source (output valid, status, data_age, found_position, entry_count,
                    input ready);
    modport sink   (input valid, status, data_age, found_position, entry_count,
                    output ready);
endinterface

// File: src/lss_dp.sv
// ----------------------------------------------------------------------------
// lss_dp: datapath of the LIFO stack with search
// Entry memory, fill level, walk pointer, result staging and output register.
// ----------------------------------------------------------------------------
module lss_dp #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lss_pkg::t_cmd     i_cmd,
    output lss_pkg::t_sts     o_sts,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_age,
    input  logic [3:0]        i_position,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_status,
    output logic [7:0]        o_data_age,
    output logic [4:0]        o_found_position,
    output logic [4:0]        o_entry_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > 4) ? CW : 4) + 1;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [CW-1:0] r_fill;
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_idx;
    logic [2:0]    r_act;
    logic [7:0]    r_age;
    logic [3:0]    r_pos;
    logic [2:0]    r_st;
    logic [7:0]    r_data;
    logic [4:0]    r_found;
    logic          r_out_valid;
    logic [2:0]    r_o_status;
    logic [7:0]    r_o_data;
    logic [4:0]    r_o_found;
    logic [4:0]    r_o_count;

    logic [XW-1:0] fill_x, ptr_x, pos_x, idx_x, top_x, slot_x;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data;

    assign fill_x = XW'(r_fill);
    assign ptr_x  = XW'(r_ptr);
    assign pos_x  = XW'(r_pos);
    assign idx_x  = XW'(r_idx);
    assign top_x  = fill_x - XW'(1);
    assign slot_x = fill_x - XW'(1) - pos_x;

    always_comb begin
        o_sts.act        = r_act;
        o_sts.full       = fill_x >= XW'(DEPTH);
        o_sts.empty      = (r_fill == '0);
        o_sts.pos_zero   = (r_pos == '0);
        o_sts.pos_beyond = pos_x >= fill_x;
        o_sts.more       = (ptr_x + XW'(1)) < fill_x;
        o_sts.shift_more = (ptr_x + XW'(2)) < fill_x;
        o_sts.match      = (r_rdata == r_age);
        o_sts.scan_more  = (idx_x + XW'(1)) < fill_x;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ptr;
        wr_en   = 1'b0;
        wr_addr = r_fill[AW-1:0];
        wr_data = r_age;
        case (i_cmd.op)
            lss_pkg::OP_PUSH: begin
                wr_en = 1'b1;
            end
            lss_pkg::OP_RD_TOP: begin
                rd_en   = 1'b1;
                rd_addr = top_x[AW-1:0];
            end
            lss_pkg::OP_RD_SLOT: begin
                rd_en   = 1'b1;
                rd_addr = slot_x[AW-1:0];
            end
            lss_pkg::OP_REM_TAKE: begin
                rd_en   = o_sts.more;
                rd_addr = r_ptr + AW'(1);
            end
            lss_pkg::OP_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr;
                wr_data = r_rdata;
                rd_en   = o_sts.shift_more;
                rd_addr = r_ptr + AW'(2);
            end
            lss_pkg::OP_SCAN: begin
                rd_en   = !o_sts.match && o_sts.scan_more;
                rd_addr = r_ptr - AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // control state: fill level and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                lss_pkg::OP_PUSH:     r_fill <= r_fill + CW'(1);
                lss_pkg::OP_CLEAR:    r_fill <= '0;
                lss_pkg::OP_TAKE: begin
                    if (r_act == lss_pkg::ACT_POP) begin
                        r_fill <= r_fill - CW'(1);
                    end
                end
                lss_pkg::OP_REM_TAKE: begin
                    if (!o_sts.more) begin
                        r_fill <= r_fill - CW'(1);
                    end
                end
                lss_pkg::OP_SHIFT: begin
                    if (!o_sts.shift_more) begin
                        r_fill <= r_fill - CW'(1);
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.op == lss_pkg::OP_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: item capture, walk pointer, result staging, output register
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            lss_pkg::OP_LATCH: begin
                r_act   <= i_action;
                r_age   <= i_age;
                r_pos   <= i_position;
                r_st    <= lss_pkg::ST_OK;
                r_data  <= '0;
                r_found <= '0;
            end
            lss_pkg::OP_FAIL: r_st <= i_cmd.st;
            lss_pkg::OP_RD_TOP: begin
                r_ptr <= top_x[AW-1:0];
                r_idx <= '0;
            end
            lss_pkg::OP_RD_SLOT: r_ptr <= slot_x[AW-1:0];
            lss_pkg::OP_TAKE:     r_data <= r_rdata;
            lss_pkg::OP_REM_TAKE: r_data <= r_rdata;
            lss_pkg::OP_SHIFT:    r_ptr <= r_ptr + AW'(1);
            lss_pkg::OP_SCAN: begin
                if (o_sts.match) begin
                    r_found <= 5'(idx_x + XW'(1));
                end else if (o_sts.scan_more) begin
                    r_ptr <= r_ptr - AW'(1);
                    r_idx <= r_idx + CW'(1);
                end else begin
                    r_st <= lss_pkg::ST_NOTFOUND;
                end
            end
            lss_pkg::OP_LOAD: begin
                r_o_status <= r_st;
                r_o_data   <= r_data;
                r_o_found  <= r_found;
                r_o_count  <= 5'(r_fill);
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_data_age       = r_o_data;
    assign o_found_position = r_o_found;
    assign o_entry_count    = r_o_count;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_x <= XW'(DEPTH))
        else $error("fill level above depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == lss_pkg::OP_PUSH |-> !o_sts.full)
        else $error("push into a full store");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == lss_pkg::OP_CLEAR |=> r_fill == '0)
        else $error("clear left entries");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == lss_pkg::OP_LOAD |-> o_sts.out_free)
        else $error("result loaded over a waiting result");

endmodule

// File: src/lss_ctrl.sv
// ----------------------------------------------------------------------------
// lss_ctrl: controller of the LIFO stack with search
// Sequences each action through the datapath, one item at a time.
// ----------------------------------------------------------------------------
module lss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lss_pkg::t_sts i_sts,
    output lss_pkg::t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TAKE,
        S_REM_TAKE,
        S_SHIFT,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = lss_pkg::OP_NONE;
        o_cmd.st = lss_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.op = lss_pkg::OP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESULT;
                unique case (i_sts.act)
                    lss_pkg::ACT_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.op = lss_pkg::OP_FAIL;
                            o_cmd.st = lss_pkg::ST_FULL;
                        end else begin
                            o_cmd.op = lss_pkg::OP_PUSH;
                        end
                    end
                    lss_pkg::ACT_POP, lss_pkg::ACT_PEEK: begin
                        if (i_sts.empty) begin
                            o_cmd.op = lss_pkg::OP_FAIL;
                            o_cmd.st = lss_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.op = lss_pkg::OP_RD_TOP;
                            n_state  = S_TAKE;
                        end
                    end
                    lss_pkg::ACT_REMOVE: begin
                        o_cmd.op = lss_pkg::OP_FAIL;
                        if (i_sts.empty) begin
                            o_cmd.st = lss_pkg::ST_EMPTY;
                        end else if (i_sts.pos_zero) begin
                            o_cmd.st = lss_pkg::ST_INVALID;
                        end else if (i_sts.pos_beyond) begin
                            o_cmd.st = lss_pkg::ST_BEYOND;
                        end else begin
                            o_cmd.op = lss_pkg::OP_RD_SLOT;
                            n_state  = S_REM_TAKE;
                        end
                    end
                    lss_pkg::ACT_SEARCH: begin
                        if (i_sts.empty) begin
                            o_cmd.op = lss_pkg::OP_FAIL;
                            o_cmd.st = lss_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.op = lss_pkg::OP_RD_TOP;
                            n_state  = S_SCAN;
                        end
                    end
                    lss_pkg::ACT_CLEAR: o_cmd.op = lss_pkg::OP_CLEAR;
                    default: o_cmd.op = lss_pkg::OP_NONE;  // count, unused code
                endcase
            end
            S_TAKE: begin
                o_cmd.op = lss_pkg::OP_TAKE;
                n_state  = S_RESULT;
            end
            S_REM_TAKE: begin
                o_cmd.op = lss_pkg::OP_REM_TAKE;
                n_state  = i_sts.more ? S_SHIFT : S_RESULT;
            end
            S_SHIFT: begin
                o_cmd.op = lss_pkg::OP_SHIFT;
                n_state  = i_sts.shift_more ? S_SHIFT : S_RESULT;
            end
            S_SCAN: begin
                o_cmd.op = lss_pkg::OP_SCAN;
                n_state  = (!i_sts.match && i_sts.scan_more) ? S_SCAN : S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = lss_pkg::OP_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE) && !(r_state == S_IDLE && i_in_valid
                          && r_in_ready);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// File: src/lifo_stack_with_search.sv
// Sequence: push, count, clear and rejected actions go from decode to the
// result state; pop and peek read and stage the top entry; search walks down
// to a match or the bottom; removal takes its entry, shifts those above down.
// Flow: one item at a time, set by the controller; the next item can be taken
// in the cycle after its result is loaded into the output register.
// Reset: synchronous, active low; empties the stack, no result pending.
// ----------------------------------------------------------------------------
// lifo_stack_with_search: bounded LIFO stack of 8-bit ages with search
// Push, pop, peek, removal at a position from the top, search by age, count
// and clear. Entries live in a DEPTH x 8 memory with one read and one write
// port; search and removal walk it one entry per cycle.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lss_in_if.sink        i_in,
    lss_out_if.source     o_out
);
    // command and status between sequencer and datapath
    lss_pkg::t_cmd cmd;
    lss_pkg::t_sts sts;
    logic          in_ready;

    // The controller takes one item, steps the datapath through it, and
    // waits in its result state only if the output register is still full.
    lss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Memory, fill level and the output register. The output register
    // decouples the sink: the next item can be taken while a result waits.
    lss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_in.action),
        .i_age            (i_in.age),
        .i_position       (i_in.position),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_status         (o_out.status),
        .o_data_age       (o_out.data_age),
        .o_found_position (o_out.found_position),
        .o_entry_count    (o_out.entry_count)
    );

    assign i_in.ready = in_ready;

endmodule
